// ----- design/bop3_pkg.sv -----
// Package for the 3x3 binary opening block: sizes, limits and register codes.
// Used by binary_opening_3x3; depends on nothing else.

package bop3_pkg;

   // Line buffer depth: widest supported row.
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int MIN_DIM    = 25;

   // Column counter / line buffer address, effective width, row counter.
   localparam int ADDR_W  = $clog2(MAX_WIDTH);
   localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int HGT_W   = $clog2(MAX_HEIGHT + 1);

   // Common width for position and limit compares.
   localparam int EXT_W = 14;

   // Configuration register width and reset values.
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_DATA_W-1:0] WIDTH_RESET  = CSR_DATA_W'(640);
   localparam logic [CSR_DATA_W-1:0] HEIGHT_RESET = CSR_DATA_W'(480);

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = CSR_INDEX_W'(1);

   // Border of the erosion zone: centres in [ERODE_LO, dim-ERODE_HI).
   localparam int ERODE_LO = 11;
   localparam int ERODE_HI = 12;

   // Same limits restated on the position (r, c) of the incoming pixel.
   // Erosion centre is (r-1, c-1), dilation centre is (r-2, c-2).
   localparam int ZONE_LO    = ERODE_LO + 1;
   localparam int ERO_HI_OFS = ERODE_HI - 1;
   localparam int DIL_HI_OFS = ERODE_LO - 2;

endpackage

// ----- design/binary_opening_3x3.sv -----
// Top level of the 3x3 binary opening (erode then dilate) over a raster pixel stream.
// Holds the input and erosion line buffers, windows, counters and result register.
// Depends on bop3_pkg.
//
//   channel   direction  handshake                 payload
//   req_      in         req_valid / req_stall     req_pixel_bit
//   rsp_      out        rsp_valid / rsp_stall     rsp_opened_bit, rsp_out_valid,
//                                                  rsp_end_of_frame
//   csr_      in         csr_valid / csr_ready     csr_index, csr_wdata
//
// One item per clock unless stalled; results come the cycle after items are taken.
// The two line buffers are read at the next column and written at the current one,
// so one read and one write port each carry a pixel per cycle.
// Reset zeroes counters and rsp_valid, presets width/height; no clearing pass is run.
// req_stall rises only while a result is held and rsp_stall is high.
// csr_ready is always high; a write to a known register restarts the frame.

module binary_opening_3x3 (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_pixel_bit,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_opened_bit,
   output logic                                rsp_out_valid,
   output logic                                rsp_end_of_frame,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bop3_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bop3_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int EW = bop3_pkg::EXT_W;

   // Configuration registers
   logic [bop3_pkg::CSR_DATA_W-1:0] width_ff, width_in;
   logic [bop3_pkg::CSR_DATA_W-1:0] height_ff, height_in;

   // Raster position of the next item
   logic [bop3_pkg::ADDR_W-1:0] col_ff, col_in;
   logic [bop3_pkg::ROW_W-1:0]  row_ff, row_in;

   // Line buffers: per column, the two most recent rows (bit 1 newer)
   logic [1:0] in_mem  [bop3_pkg::MAX_WIDTH];
   logic [1:0] ero_mem [bop3_pkg::MAX_WIDTH];
   logic [1:0] in_rd_ff;
   logic [1:0] ero_rd_ff;

   // Window columns: input c-1 and c-2, erosion c-2 and c-3, three rows each
   logic [5:0] in_win_ff, in_win_in;
   logic [5:0] ero_win_ff, ero_win_in;

   // Result register
   logic rsp_valid_ff, rsp_valid_in;
   logic opened_ff, opened_in;
   logic outv_ff, outv_in;
   logic eof_ff, eof_in;

   logic                      accept;
   logic                      cfg_wr;
   logic [bop3_pkg::WIDTH_W-1:0] w_eff;
   logic [bop3_pkg::HGT_W-1:0]   h_eff;
   logic [EW-1:0]             col_x, row_x, w_x, h_x;
   logic                      col_last, row_last;
   logic                      ero_zone, dil_zone;
   logic [2:0]                in_col, ero_col;
   logic                      ero_bit;
   logic [bop3_pkg::ADDR_W-1:0] ero_rd_addr;

   // Handshakes
   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign csr_ready = 1'b1;
   assign cfg_wr    = csr_valid && csr_ready &&
                      (csr_index == bop3_pkg::REG_FRAME_WIDTH ||
                       csr_index == bop3_pkg::REG_FRAME_HEIGHT);

   // Saturate the frame size to the supported range
   always_comb begin
      if (EW'(width_ff) < EW'(bop3_pkg::MIN_DIM)) begin
         w_eff = bop3_pkg::WIDTH_W'(bop3_pkg::MIN_DIM);
      end else if (EW'(width_ff) > EW'(bop3_pkg::MAX_WIDTH)) begin
         w_eff = bop3_pkg::WIDTH_W'(bop3_pkg::MAX_WIDTH);
      end else begin
         w_eff = bop3_pkg::WIDTH_W'(width_ff);
      end
      if (EW'(height_ff) < EW'(bop3_pkg::MIN_DIM)) begin
         h_eff = bop3_pkg::HGT_W'(bop3_pkg::MIN_DIM);
      end else if (EW'(height_ff) > EW'(bop3_pkg::MAX_HEIGHT)) begin
         h_eff = bop3_pkg::HGT_W'(bop3_pkg::MAX_HEIGHT);
      end else begin
         h_eff = bop3_pkg::HGT_W'(height_ff);
      end
   end

   // Position compares
   assign col_x    = EW'(col_ff);
   assign row_x    = EW'(row_ff);
   assign w_x      = EW'(w_eff);
   assign h_x      = EW'(h_eff);
   assign col_last = (col_x + EW'(1)) == w_x;
   assign row_last = (row_x + EW'(1)) == h_x;

   assign ero_zone = (row_x >= EW'(bop3_pkg::ZONE_LO)) &&
                     (row_x + EW'(bop3_pkg::ERO_HI_OFS) < h_x) &&
                     (col_x >= EW'(bop3_pkg::ZONE_LO)) &&
                     (col_x + EW'(bop3_pkg::ERO_HI_OFS) < w_x);
   assign dil_zone = (row_x >= EW'(bop3_pkg::ZONE_LO)) &&
                     (row_x + EW'(bop3_pkg::DIL_HI_OFS) < h_x) &&
                     (col_x >= EW'(bop3_pkg::ZONE_LO)) &&
                     (col_x + EW'(bop3_pkg::DIL_HI_OFS) < w_x);

   // Advance the raster position; restart on reset or register write
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready && csr_index == bop3_pkg::REG_FRAME_WIDTH) begin
         width_in = csr_wdata;
      end
      if (csr_valid && csr_ready && csr_index == bop3_pkg::REG_FRAME_HEIGHT) begin
         height_in = csr_wdata;
      end
      if (reset || cfg_wr) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // Erode at (r-1, c-1), then dilate at (r-2, c-2)
   assign in_col      = {req_pixel_bit, in_rd_ff};
   assign ero_bit     = ero_zone && (&{in_col, in_win_ff});
   assign ero_col     = {ero_bit, ero_rd_ff};
   assign in_win_in   = {in_col, in_win_ff[5:3]};
   assign ero_win_in  = {ero_col, ero_win_ff[5:3]};
   assign ero_rd_addr = col_in - 1'b1;

   // Result for the item being taken
   always_comb begin
      opened_in = dil_zone && (|{ero_col, ero_win_ff});
      outv_in   = (row_ff > bop3_pkg::ROW_W'(2)) ||
                  (row_ff == bop3_pkg::ROW_W'(2) && col_ff >= bop3_pkg::ADDR_W'(2));
      eof_in    = row_last && col_last;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // Line buffers: write the current column, read ahead at the next one
   always_ff @(posedge clock) begin
      if (accept) begin
         in_mem[col_ff] <= {req_pixel_bit, in_rd_ff[1]};
      end
      in_rd_ff <= in_mem[col_in];
   end

   always_ff @(posedge clock) begin
      if (accept && col_ff != '0) begin
         ero_mem[col_ff - 1'b1] <= {ero_bit, ero_rd_ff[1]};
      end
      ero_rd_ff <= ero_mem[ero_rd_addr];
   end

   // Windows and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         in_win_ff  <= in_win_in;
         ero_win_ff <= ero_win_in;
         opened_ff  <= opened_in;
         outv_ff    <= outv_in;
         eof_ff     <= eof_in;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= bop3_pkg::WIDTH_RESET;
         height_ff    <= bop3_pkg::HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_opened_bit   = opened_ff;
   assign rsp_out_valid    = outv_ff;
   assign rsp_end_of_frame = eof_ff;

   // Checks
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("taken item produced no result");

   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      col_x < w_x)
      else $error("column counter outside frame width");

   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      row_x < h_x)
      else $error("row counter outside frame height");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && col_last && row_last && !cfg_wr) |=> (col_ff == '0 && row_ff == '0))
      else $error("position did not wrap at end of frame");

endmodule
